[rtl/core/itp_pkg.sv]
// shared types, character codes and classification functions for the infix-to-postfix core
`default_nettype none
package itp_pkg;

  localparam int unsigned SYM_W           = 8;
  localparam int unsigned ST_W            = 2;
  localparam int unsigned OUT_TDATA_W     = 16;
  localparam int unsigned DEF_STACK_DEPTH = 32;

  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_MUL   = 8'h2A;
  localparam logic [SYM_W-1:0] CH_DIV   = 8'h2F;
  localparam logic [SYM_W-1:0] CH_OPEN  = 8'h28;
  localparam logic [SYM_W-1:0] CH_CLOSE = 8'h29;
  localparam logic [SYM_W-1:0] CH_NUL   = 8'h00;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [ST_W-1:0] ST_UNM_CLOSE = 2'd2;
  localparam logic [ST_W-1:0] ST_UNM_OPEN  = 2'd3;

  // classification of the current character and the stack top
  typedef struct packed {
    logic c_alnum;
    logic c_open;
    logic c_close;
    logic c_op;
    logic t_open;
    logic t_pops;
  } itp_cls_t;

  function automatic logic is_op(input logic [SYM_W-1:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_MUL) || (c == CH_DIV);
  endfunction

  function automatic logic prec(input logic [SYM_W-1:0] c);
    return (c == CH_MUL) || (c == CH_DIV);
  endfunction

  function automatic logic is_alnum(input logic [SYM_W-1:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

endpackage
`default_nettype wire

[rtl/core/itp_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none
module itp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/core/itp_cmp.sv]
// shared classify and precedence compare unit used in the idle and loop sequencer steps
`default_nettype none
module itp_cmp
  import itp_pkg::*;
(
  input  wire logic [SYM_W-1:0] cur_sym,
  input  wire logic [SYM_W-1:0] top_sym,
  output itp_cls_t              cls
);

  always_comb begin
    cls.c_alnum = is_alnum(cur_sym);
    cls.c_open  = (cur_sym == CH_OPEN);
    cls.c_close = (cur_sym == CH_CLOSE);
    cls.c_op    = is_op(cur_sym);
    cls.t_open  = (top_sym == CH_OPEN);
    // left-associative: pop while top is an operator of equal or higher precedence
    cls.t_pops  = is_op(top_sym) && (prec(top_sym) >= prec(cur_sym));
  end

endmodule
`default_nettype wire

[rtl/core/infix_to_postfix_converter_core.sv]
// top level of the shunting-yard infix-to-postfix converter
// a non-final operand passes through the hold slot and then the output register
// one character is in work at a time (in_tready only in S_IDLE); a push or an unmatched close adds
//   a state, and each stack entry read (each pop and the top test that ends an operator) passes S_FETCH and S_LOOP
// for the ram read; a final character also flushes the stack; output stalls lengthen all of these
// reset (rst_n low, synchronous) empties the stack and drops any pending result
`default_nettype none
module infix_to_postfix_converter_core
  import itp_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [SYM_W-1:0]       in_tdata,   // [7:0] symbol
  input  wire logic                   in_tlast,   // final_req
  // result stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [7:0] out_symbol, [9:8] status, rest zero
  output logic                        out_tlast,  // last_of_run
  output logic                        out_tuser   // expr_done
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_AFTER, S_FETCH, S_LOOP, S_PUSH, S_UNCL, S_FLEND, S_FINISH
  } state_t;

  typedef enum logic [1:0] {PH_OP, PH_CLOSE, PH_FLUSH} phase_t;

  // sequencer and stack pointer
  state_t           state_r, state_nxt;
  phase_t           ph_r, ph_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  // current character
  logic [SYM_W-1:0] c_r, c_nxt;
  logic             fin_r, fin_nxt;
  logic             open_r, open_nxt;
  // one-deep lookahead slot so the last result of a run can be tagged
  logic             hold_v_r, hold_v_nxt;
  logic [SYM_W-1:0] hold_sym_r, hold_sym_nxt;
  logic [ST_W-1:0]  hold_st_r, hold_st_nxt;
  // output register
  logic             out_v_r, out_v_nxt;
  logic [SYM_W-1:0] out_sym_r, out_sym_nxt;
  logic [ST_W-1:0]  out_st_r, out_st_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_done_r, out_done_nxt;

  // stack ram
  logic             ram_we;
  logic [SYM_W-1:0] ram_wdata;
  logic [SYM_W-1:0] top_sym;
  logic [CW-1:0]    cnt_dec;

  // shared compare unit
  logic [SYM_W-1:0] cmp_c;
  itp_cls_t         cls;

  // result generation
  logic             out_free;
  logic             gen_ok;
  logic             gen_req;
  logic [SYM_W-1:0] gen_sym;
  logic [ST_W-1:0]  gen_st;
  logic             full;

  assign cnt_dec  = cnt_r - CW'(1);
  assign full     = (cnt_r >= CW'(STACK_DEPTH));
  assign out_free = !out_v_r || out_tready;
  assign gen_ok   = !hold_v_r || out_free;
  assign cmp_c    = (state_r == S_IDLE) ? in_tdata : c_r;

  itp_ram #(
    .WIDTH (SYM_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (cnt_dec[AW-1:0]),
    .rdata (top_sym)
  );

  itp_cmp u_cmp (
    .cur_sym (cmp_c),
    .top_sym (top_sym),
    .cls     (cls)
  );

  always_comb begin
    state_nxt    = state_r;
    ph_nxt       = ph_r;
    cnt_nxt      = cnt_r;
    c_nxt        = c_r;
    fin_nxt      = fin_r;
    open_nxt     = open_r;
    hold_v_nxt   = hold_v_r;
    hold_sym_nxt = hold_sym_r;
    hold_st_nxt  = hold_st_r;
    out_v_nxt    = out_v_r && !out_tready;
    out_sym_nxt  = out_sym_r;
    out_st_nxt   = out_st_r;
    out_last_nxt = out_last_r;
    out_done_nxt = out_done_r;
    ram_we       = 1'b0;
    ram_wdata    = c_r;
    gen_req      = 1'b0;
    gen_sym      = CH_NUL;
    gen_st       = ST_OK;
    in_tready    = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          c_nxt    = in_tdata;
          fin_nxt  = in_tlast;
          open_nxt = 1'b0;
          if (cls.c_alnum) begin
            gen_req   = 1'b1;
            gen_sym   = in_tdata;
            state_nxt = S_AFTER;
          end else if (cls.c_open) begin
            if (full) begin
              gen_req = 1'b1;
              gen_st  = ST_OVERFLOW;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = in_tdata;
              cnt_nxt   = cnt_r + CW'(1);
            end
            state_nxt = S_AFTER;
          end else if (cls.c_close) begin
            ph_nxt    = PH_CLOSE;
            state_nxt = (cnt_r == '0) ? S_UNCL : S_FETCH;
          end else if (cls.c_op) begin
            ph_nxt    = PH_OP;
            state_nxt = (cnt_r == '0) ? S_PUSH : S_FETCH;
          end else begin
            state_nxt = S_AFTER;
          end
        end
      end
      // decide whether the final flush follows
      S_AFTER: begin
        if (fin_r) begin
          ph_nxt    = PH_FLUSH;
          state_nxt = (cnt_r == '0) ? S_FLEND : S_FETCH;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      // stack top read in flight
      S_FETCH: begin
        state_nxt = S_LOOP;
      end
      S_LOOP: begin
        case (ph_r)
          PH_OP: begin
            if (!cls.t_pops) begin
              state_nxt = S_PUSH;
            end else if (gen_ok) begin
              gen_req   = 1'b1;
              gen_sym   = top_sym;
              cnt_nxt   = cnt_dec;
              state_nxt = (cnt_r == CW'(1)) ? S_PUSH : S_FETCH;
            end
          end
          PH_CLOSE: begin
            if (cls.t_open) begin
              cnt_nxt   = cnt_dec;
              state_nxt = S_AFTER;
            end else if (gen_ok) begin
              gen_req   = 1'b1;
              gen_sym   = top_sym;
              cnt_nxt   = cnt_dec;
              state_nxt = (cnt_r == CW'(1)) ? S_UNCL : S_FETCH;
            end
          end
          default: begin
            // final flush: stacked opens are dropped and remembered
            if (cls.t_open) begin
              open_nxt  = 1'b1;
              cnt_nxt   = cnt_dec;
              state_nxt = (cnt_r == CW'(1)) ? S_FLEND : S_FETCH;
            end else if (gen_ok) begin
              gen_req   = 1'b1;
              gen_sym   = top_sym;
              cnt_nxt   = cnt_dec;
              state_nxt = (cnt_r == CW'(1)) ? S_FLEND : S_FETCH;
            end
          end
        endcase
      end
      S_PUSH: begin
        if (full) begin
          if (gen_ok) begin
            gen_req   = 1'b1;
            gen_st    = ST_OVERFLOW;
            state_nxt = S_AFTER;
          end
        end else begin
          ram_we    = 1'b1;
          ram_wdata = c_r;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_AFTER;
        end
      end
      S_UNCL: begin
        if (gen_ok) begin
          gen_req   = 1'b1;
          gen_st    = ST_UNM_CLOSE;
          state_nxt = S_AFTER;
        end
      end
      S_FLEND: begin
        if (!open_r) begin
          state_nxt = S_FINISH;
        end else if (gen_ok) begin
          gen_req   = 1'b1;
          gen_st    = ST_UNM_OPEN;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // release the held result tagged as last of the run
        if (hold_v_r) begin
          if (out_free) begin
            out_v_nxt    = 1'b1;
            out_sym_nxt  = hold_sym_r;
            out_st_nxt   = hold_st_r;
            out_last_nxt = 1'b1;
            out_done_nxt = fin_r;
            hold_v_nxt   = 1'b0;
            state_nxt    = S_IDLE;
          end
        end else if (fin_r) begin
          // final character with nothing emitted still marks the expression end
          if (out_free) begin
            out_v_nxt    = 1'b1;
            out_sym_nxt  = CH_NUL;
            out_st_nxt   = ST_OK;
            out_last_nxt = 1'b1;
            out_done_nxt = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a new result pushes the held one out as a middle result of the run
    if (gen_req) begin
      if (hold_v_r) begin
        out_v_nxt    = 1'b1;
        out_sym_nxt  = hold_sym_r;
        out_st_nxt   = hold_st_r;
        out_last_nxt = 1'b0;
        out_done_nxt = 1'b0;
      end
      hold_v_nxt   = 1'b1;
      hold_sym_nxt = gen_sym;
      hold_st_nxt  = gen_st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ph_r     <= PH_OP;
      cnt_r    <= '0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ph_r     <= ph_nxt;
      cnt_r    <= cnt_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    c_r        <= c_nxt;
    fin_r      <= fin_nxt;
    open_r     <= open_nxt;
    hold_sym_r <= hold_sym_nxt;
    hold_st_r  <= hold_st_nxt;
    out_sym_r  <= out_sym_nxt;
    out_st_r   <= out_st_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {(OUT_TDATA_W - SYM_W - ST_W)'(0), out_st_r, out_sym_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

endmodule
`default_nettype wire

[rtl/core/itp_checker.sv]
// port-level assertion checker for the infix-to-postfix core, with its bind
`default_nettype none
module itp_checker
  import itp_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tlast,
  input wire logic                   out_tuser
);

  // one character in work at a time
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a character is in work");

  // status-only results carry a null symbol
  a_status_null: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[9:8] != ST_OK)) |-> (out_tdata[7:0] == CH_NUL))
    else $error("status result with nonzero symbol");

  // expression end is always the last result of its run
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("expr_done without last_of_run");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("result dropped while stalled");

endmodule

bind infix_to_postfix_converter_core itp_checker u_itp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
`default_nettype wire
